FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by capsule_pair_overlap; each expects clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define CPO_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante implies cons a fixed number of cycles later
`define CPO_ASSERT_AFTER(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) else $error(msg);

`endif

FILE: hw/rtl/cpo_pkg.sv
// ---------------------------------------------------------------------------
// cpo_pkg
// Widths, types, stage indexes and arithmetic helpers of the capsule test.
// ---------------------------------------------------------------------------
package cpo_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int PARAM_BITS = 16;

  localparam int IN_W      = 48;
  localparam int RAD_W     = 16;
  localparam int DIST_BITS = 36;

  localparam int PAD_W  = (3 * COORD_BITS > IN_W) ? 3 * COORD_BITS : IN_W;
  localparam int DW     = COORD_BITS + 1;
  localparam int DOT_W  = 2 * DW + 2;
  localparam int DOT_H  = DOT_W / 2;
  localparam int PW     = 2 * DOT_W;
  localparam int TN_W   = DOT_W + PARAM_BITS + 3;
  localparam int DIV_W  = ((PW > TN_W) ? PW : TN_W) + 1;
  localparam int RS_W   = RAD_W + 1;
  localparam int MP_W   = DW + PARAM_BITS + 2;
  localparam int CW     = DW + PARAM_BITS + 4;
  localparam int CW_H   = CW / 2;
  localparam int SQ_W   = 2 * CW + 2;
  localparam int DIST_IW = SQ_W + 2;
  localparam int LIM_W  = 2 * RS_W + 2 * PARAM_BITS;
  localparam int SH_AMT = 2 * (FRAC_BITS + PARAM_BITS) - 16;

  localparam logic [PARAM_BITS:0]  PARAM_ONE = {1'b1, {PARAM_BITS{1'b0}}};
  localparam logic [DIST_BITS-1:0] DQ_MAX    = {DIST_BITS{1'b1}};

  // divider: one entry stage plus one stage per quotient bit
  localparam int DIV_LAT = PARAM_BITS + 1;

  // pipeline stage indexes
  localparam int S_UNP  = 0;
  localparam int S_DOT  = 1;
  localparam int S_PP   = 2;
  localparam int S_SUM  = 3;
  localparam int S_Q1   = S_SUM + DIV_LAT + 1;
  localparam int S_TN   = S_Q1 + 1;
  localparam int S_SEL  = S_TN + 1;
  localparam int S_Q2   = S_SEL + DIV_LAT + 1;
  localparam int S_MP   = S_Q2 + 1;
  localparam int S_CV   = S_MP + 1;
  localparam int S_SP   = S_CV + 1;
  localparam int S_SQ   = S_SP + 1;
  localparam int S_DIST = S_SQ + 1;
  localparam int S_OUT  = S_DIST + 1;

  typedef logic [PAD_W-1:0]               pad_t;
  typedef logic signed [COORD_BITS-1:0]   coord_t;
  typedef logic signed [DW-1:0]           diff_t;
  typedef logic signed [DOT_W-1:0]        dot_t;
  typedef logic signed [PW-1:0]           prod_t;
  typedef prod_t [3:0]                    prod4_t;
  typedef logic signed [DIV_W-1:0]        div_t;
  typedef logic [PARAM_BITS:0]            param_t;
  typedef logic signed [MP_W-1:0]         mp_t;
  typedef logic signed [CW-1:0]           cw_t;
  typedef logic signed [SQ_W-1:0]         sq_t;
  typedef sq_t [2:0]                      sq3_t;
  typedef logic [DIST_IW-1:0]             dist_t;
  typedef logic [LIM_W-1:0]               lim_t;
  typedef logic [DIST_BITS-1:0]           dq_t;
  typedef logic [RS_W-1:0]                rs_t;

  // how the second division result is applied
  typedef enum logic [2:0] {
    MODE_KEEP,
    MODE_T0,
    MODE_T1,
    MODE_EQ,
    MODE_T
  } mode_t;

  typedef struct packed {
    diff_t [2:0]  d1;
    diff_t [2:0]  d2;
    diff_t [2:0]  r;
    rs_t          rs;
    dot_t         a;
    dot_t         b;
    dot_t         c;
    dot_t         e;
    dot_t         f;
    logic         a0;
    logic         e0;
    logic         gen;
    prod4_t [3:0] pp;
    prod_t        dd;
    prod_t        n1;
    div_t         tn;
    div_t         ed;
    div_t         num;
    div_t         den;
    mode_t        mode;
    param_t       s;
    param_t       t;
    mp_t [2:0]    ps;
    mp_t [2:0]    pt;
    cw_t [2:0]    cv;
    sq3_t [2:0]   sp;
    sq_t [2:0]    sq;
    dist_t        dsq;
    lim_t         lim;
    logic         ov;
    dq_t          dq;
  } item_t;

  function automatic dot_t dot3(diff_t [2:0] p, diff_t [2:0] q);
    dot_t acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      acc = acc + $signed(p[i]) * $signed(q[i]);
    end
    return acc;
  endfunction

  // four half-width partial products of x*y, already shifted into place
  function automatic prod4_t split_mul(dot_t x, dot_t y);
    logic signed [DOT_H:0]         xl, yl;
    logic signed [DOT_W-DOT_H-1:0] xh, yh;
    prod_t  p;
    prod4_t r;
    xl = $signed({1'b0, x[DOT_H-1:0]});
    yl = $signed({1'b0, y[DOT_H-1:0]});
    xh = x[DOT_W-1:DOT_H];
    yh = y[DOT_W-1:DOT_H];
    p = xl * yl;
    r[0] = p;
    p = xh * yl;
    r[1] = p <<< DOT_H;
    p = xl * yh;
    r[2] = p <<< DOT_H;
    p = xh * yh;
    r[3] = p <<< (2 * DOT_H);
    return r;
  endfunction

  // three partial products of c*c
  function automatic sq3_t sq_split(cw_t c);
    logic signed [CW_H:0]        lo;
    logic signed [CW-CW_H-1:0]   hi;
    sq_t  p;
    sq3_t r;
    lo = $signed({1'b0, c[CW_H-1:0]});
    hi = c[CW-1:CW_H];
    p = lo * lo;
    r[0] = p;
    p = hi * lo;
    r[1] = p <<< (CW_H + 1);
    p = hi * hi;
    r[2] = p <<< (2 * CW_H);
    return r;
  endfunction

endpackage

FILE: hw/rtl/capsule_pair_overlap.sv
// ---------------------------------------------------------------------------
// capsule_pair_overlap
// Result strobe is the valid bit of the last stage (S_OUT in cpo_pkg).
// Throughput: one word per cycle; busy stays low, the two 17-stage
// pipelined dividers and the multiply stages all advance every cycle.
// Reset: synchronous, active low; clears all valid bits, drops words in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module capsule_pair_overlap (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cpo_pkg::IN_W-1:0]      in_seg_a_start,
  input  logic [cpo_pkg::IN_W-1:0]      in_seg_a_end,
  input  logic [cpo_pkg::IN_W-1:0]      in_seg_b_start,
  input  logic [cpo_pkg::IN_W-1:0]      in_seg_b_end,
  input  logic [cpo_pkg::RAD_W-1:0]     in_radius_a,
  input  logic [cpo_pkg::RAD_W-1:0]     in_radius_b,
  output logic                          out_valid,
  output logic                          out_overlap,
  output logic [cpo_pkg::DIST_BITS-1:0] out_dist_squared,
  output cpo_pkg::param_t               out_param_s,
  output cpo_pkg::param_t               out_param_t
);
  import cpo_pkg::*;

  // one payload register per stage, valid bits travel alongside
  item_t            st_r   [0:S_OUT];
  item_t            st_nxt [0:S_OUT];
  logic [S_OUT:0]   v_r;

  div_t   div1_num, div1_den;
  param_t div1_quo, div2_quo;

  // nothing ever holds the pipe: take a word every cycle
  assign busy = 1'b0;

  always_comb begin
    item_t            it;
    coord_t [2:0]     ca0, ca1, cb0, cb1;
    pad_t             pa0, pa1, pb0, pb1;
    div_t             tmp;
    cw_t              tmpc;
    lim_t             tmpl;
    dist_t            dsh;

    // advance every stage by default
    for (int k = 1; k <= S_OUT; k++) begin
      st_nxt[k] = st_r[k-1];
    end

    // unpack corners, form edge and offset vectors
    it  = '0;
    pa0 = pad_t'(in_seg_a_start);
    pa1 = pad_t'(in_seg_a_end);
    pb0 = pad_t'(in_seg_b_start);
    pb1 = pad_t'(in_seg_b_end);
    for (int i = 0; i < 3; i++) begin
      ca0[i] = pa0[i*COORD_BITS +: COORD_BITS];
      ca1[i] = pa1[i*COORD_BITS +: COORD_BITS];
      cb0[i] = pb0[i*COORD_BITS +: COORD_BITS];
      cb1[i] = pb1[i*COORD_BITS +: COORD_BITS];
      it.d1[i] = $signed(ca1[i]) - $signed(ca0[i]);
      it.d2[i] = $signed(cb1[i]) - $signed(cb0[i]);
      it.r[i]  = $signed(ca0[i]) - $signed(cb0[i]);
    end
    it.rs = {1'b0, in_radius_a} + {1'b0, in_radius_b};
    st_nxt[S_UNP] = it;

    // dot products
    it   = st_r[S_DOT-1];
    it.a = dot3(it.d1, it.d1);
    it.e = dot3(it.d2, it.d2);
    it.f = dot3(it.d2, it.r);
    it.c = dot3(it.d1, it.r);
    it.b = dot3(it.d1, it.d2);
    st_nxt[S_DOT] = it;

    // partial products of the wide cross terms
    it       = st_r[S_PP-1];
    it.pp[0] = split_mul(it.a, it.e);
    it.pp[1] = split_mul(it.b, it.b);
    it.pp[2] = split_mul(it.b, it.f);
    it.pp[3] = split_mul(it.c, it.e);
    st_nxt[S_PP] = it;

    // denominator a*e-b*b and first numerator b*f-c*e
    it    = st_r[S_SUM-1];
    it.dd = (it.pp[0][0] + it.pp[0][1] + it.pp[0][2] + it.pp[0][3])
          - (it.pp[1][0] + it.pp[1][1] + it.pp[1][2] + it.pp[1][3]);
    it.n1 = (it.pp[2][0] + it.pp[2][1] + it.pp[2][2] + it.pp[2][3])
          - (it.pp[3][0] + it.pp[3][1] + it.pp[3][2] + it.pp[3][3]);
    it.a0 = (it.a == '0);
    it.e0 = (it.e == '0);
    st_nxt[S_SUM] = it;

    // apply first quotient, start t numerator b*s
    it     = st_r[S_Q1-1];
    it.gen = !it.a0 && !it.e0;
    priority if (it.a0 && it.e0) begin
      it.s = '0;
      it.t = '0;
    end else if (it.a0) begin
      it.s = '0;
      it.t = div1_quo;
    end else begin
      it.s = div1_quo;
      it.t = '0;
    end
    it.tn = it.b * $signed({1'b0, it.s});
    st_nxt[S_Q1] = it;

    // t numerator and denominator, both scaled by one
    it    = st_r[S_TN-1];
    tmp   = div_t'(it.f);
    it.tn = it.tn + (tmp <<< PARAM_BITS);
    tmp   = div_t'(it.e);
    it.ed = tmp <<< PARAM_BITS;
    st_nxt[S_TN] = it;

    // choose the second division: t itself, or s again after clamping t
    it = st_r[S_SEL-1];
    priority if (!it.gen) begin
      it.mode = MODE_KEEP;
      it.num  = '0;
      it.den  = div_t'(1);
    end else if (it.tn < 0) begin
      it.mode = MODE_T0;
      tmp     = div_t'(it.c);
      it.num  = -tmp;
      it.den  = div_t'(it.a);
    end else if (it.tn > it.ed) begin
      it.mode = MODE_T1;
      tmp     = div_t'(it.b);
      it.num  = tmp - div_t'(it.c);
      it.den  = div_t'(it.a);
    end else if (it.tn == it.ed) begin
      it.mode = MODE_EQ;
      it.num  = '0;
      it.den  = div_t'(1);
    end else begin
      it.mode = MODE_T;
      it.num  = it.tn;
      it.den  = it.ed;
    end
    st_nxt[S_SEL] = it;

    // apply second quotient
    it = st_r[S_Q2-1];
    unique case (it.mode)
      MODE_T0: begin
        it.t = '0;
        it.s = div2_quo;
      end
      MODE_T1: begin
        it.t = PARAM_ONE;
        it.s = div2_quo;
      end
      MODE_EQ: begin
        it.t = PARAM_ONE;
      end
      MODE_T: begin
        it.t = div2_quo;
      end
      default: begin
        // hold s and t from the first division
      end
    endcase
    st_nxt[S_Q2] = it;

    // closest-point offsets: d1*s and d2*t
    it = st_r[S_MP-1];
    for (int i = 0; i < 3; i++) begin
      it.ps[i] = $signed(it.d1[i]) * $signed({1'b0, it.s});
      it.pt[i] = $signed(it.d2[i]) * $signed({1'b0, it.t});
    end
    st_nxt[S_MP] = it;

    // separation vector, scaled by one
    it = st_r[S_CV-1];
    for (int i = 0; i < 3; i++) begin
      tmpc     = cw_t'(it.r[i]);
      it.cv[i] = (tmpc <<< PARAM_BITS) + it.ps[i] - it.pt[i];
    end
    st_nxt[S_CV] = it;

    it = st_r[S_SP-1];
    for (int i = 0; i < 3; i++) begin
      it.sp[i] = sq_split(it.cv[i]);
    end
    st_nxt[S_SP] = it;

    it = st_r[S_SQ-1];
    for (int i = 0; i < 3; i++) begin
      it.sq[i] = it.sp[i][0] + it.sp[i][1] + it.sp[i][2];
    end
    st_nxt[S_SQ] = it;

    // exact squared distance and squared radius sum on the same scale
    it      = st_r[S_DIST-1];
    it.dsq  = dist_t'(it.sq[0] + it.sq[1] + it.sq[2]);
    tmpl    = lim_t'(it.rs);
    it.lim  = (tmpl * tmpl) << (2 * PARAM_BITS);
    st_nxt[S_DIST] = it;

    // overlap flag, drop fraction bits and saturate the distance
    it    = st_r[S_OUT-1];
    it.ov = (it.dsq < it.lim);
    dsh   = it.dsq >> SH_AMT;
    if (dsh > dist_t'(DQ_MAX)) begin
      it.dq = DQ_MAX;
    end else begin
      it.dq = dsh[DIST_BITS-1:0];
    end
    st_nxt[S_OUT] = it;
  end

  // first division: t for a point segment a, s otherwise
  always_comb begin
    priority if (st_r[S_SUM].a0 && st_r[S_SUM].e0) begin
      div1_num = '0;
      div1_den = div_t'(1);
    end else if (st_r[S_SUM].a0) begin
      div1_num = div_t'(st_r[S_SUM].f);
      div1_den = div_t'(st_r[S_SUM].e);
    end else if (st_r[S_SUM].e0) begin
      div1_num = -div_t'(st_r[S_SUM].c);
      div1_den = div_t'(st_r[S_SUM].a);
    end else if (st_r[S_SUM].dd > 0) begin
      div1_num = div_t'(st_r[S_SUM].n1);
      div1_den = div_t'(st_r[S_SUM].dd);
    end else begin
      // parallel: s starts at zero
      div1_num = '0;
      div1_den = div_t'(1);
    end
  end

  cpo_div u_div1 (
    .clk (clk),
    .num (div1_num),
    .den (div1_den),
    .quo (div1_quo)
  );

  cpo_div u_div2 (
    .clk (clk),
    .num (st_r[S_SEL].num),
    .den (st_r[S_SEL].den),
    .quo (div2_quo)
  );

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[S_OUT-1:0], start && !busy};
    end
  end

  assign out_valid        = v_r[S_OUT];
  assign out_overlap      = st_r[S_OUT].ov;
  assign out_dist_squared = st_r[S_OUT].dq;
  assign out_param_s      = st_r[S_OUT].s;
  assign out_param_t      = st_r[S_OUT].t;

  `CPO_ASSERT_AFTER(a_fixed_latency, start && !busy, S_OUT + 1, out_valid, "word lost in pipe")
  `CPO_ASSERT(a_no_phantom, out_valid, $past(start, S_OUT + 1), "result without a taken word")
  `CPO_ASSERT(a_param_range, out_valid, (out_param_s <= PARAM_ONE) && (out_param_t <= PARAM_ONE), "parameter above one")

endmodule

FILE: hw/rtl/cpo_div.sv
// ---------------------------------------------------------------------------
// cpo_div
// Pipelined clamped fraction divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module cpo_div (
  input  logic            clk,
  input  cpo_pkg::div_t   num,
  input  cpo_pkg::div_t   den,
  output cpo_pkg::param_t quo
);
  import cpo_pkg::*;

  typedef logic [DIV_W:0] rem_t;

  rem_t                  rem_r   [0:PARAM_BITS];
  rem_t                  rem_nxt [0:PARAM_BITS];
  rem_t                  den_r   [0:PARAM_BITS];
  rem_t                  den_nxt [0:PARAM_BITS];
  logic [PARAM_BITS-1:0] q_r     [0:PARAM_BITS];
  logic [PARAM_BITS-1:0] q_nxt   [0:PARAM_BITS];
  logic                  lo_r    [0:PARAM_BITS];
  logic                  lo_nxt  [0:PARAM_BITS];
  logic                  hi_r    [0:PARAM_BITS];
  logic                  hi_nxt  [0:PARAM_BITS];

  always_comb begin
    rem_t sh;
    // entry: classify, numerator is the first remainder
    rem_nxt[0] = {1'b0, num};
    den_nxt[0] = {1'b0, den};
    q_nxt[0]   = '0;
    lo_nxt[0]  = (num <= 0);
    hi_nxt[0]  = (num >= den);
    for (int k = 1; k <= PARAM_BITS; k++) begin
      sh         = {rem_r[k-1][DIV_W-1:0], 1'b0};
      den_nxt[k] = den_r[k-1];
      lo_nxt[k]  = lo_r[k-1];
      hi_nxt[k]  = hi_r[k-1];
      if (sh >= den_r[k-1]) begin
        rem_nxt[k] = sh - den_r[k-1];
        q_nxt[k]   = {q_r[k-1][PARAM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = sh;
        q_nxt[k]   = {q_r[k-1][PARAM_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
  end

  always_comb begin
    priority if (lo_r[PARAM_BITS]) begin
      quo = '0;
    end else if (hi_r[PARAM_BITS]) begin
      quo = PARAM_ONE;
    end else begin
      quo = {1'b0, q_r[PARAM_BITS]};
    end
  end

endmodule
